@@ hw/rtl/svsw_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none

package svsw_pkg;

  // one input tick: sampled data line plus an optional display request
  typedef struct packed {
    logic       req_valid;
    logic [4:0] glyph_0;
    logic [4:0] glyph_1;
    logic [4:0] glyph_2;
    logic [4:0] glyph_3;
    logic       colon_on;
    logic       data_line_in;
  } in_t;

  // one result per tick: pin levels and sequence status
  typedef struct packed {
    logic clock_line;
    logic data_line_out;
    logic busy_res;
    logic done_res;
    logic ack_missing;
  } out_t;

  // configuration registers as seen by the sequencer
  typedef struct packed {
    logic [2:0] brightness;
    logic       display_enable;
    logic [7:0] ack_wait_limit;
    logic [7:0] ticks_per_us;
  } cfg_t;

  // configuration register indexes
  typedef enum logic [1:0] {
    REG_BRIGHTNESS     = 2'd0,
    REG_DISPLAY_ENABLE = 2'd1,
    REG_ACK_WAIT_LIMIT = 2'd2,
    REG_TICKS_PER_US   = 2'd3
  } cfg_reg_t;

  // sequencer steps
  typedef enum logic [3:0] {
    ST_IDLE = 4'd0,
    ST_ST1  = 4'd1,
    ST_ST2  = 4'd2,
    ST_BLO  = 4'd3,
    ST_BHI  = 4'd4,
    ST_AK1  = 4'd5,
    ST_AK2  = 4'd6,
    ST_AK3  = 4'd7,
    ST_AK4  = 4'd8,
    ST_SP1  = 4'd9,
    ST_SP2  = 4'd10,
    ST_SP3  = 4'd11,
    ST_SP4  = 4'd12
  } step_t;

  // command bytes
  localparam logic [7:0] CMD_AUTO_INC = 8'h40;
  localparam logic [7:0] CMD_ADDR     = 8'hC0;
  localparam logic [7:0] CMD_DISP     = 8'h80;
  localparam logic [7:0] COLON_MASK   = 8'h80;
  localparam logic [7:0] SEG_BLANK    = 8'h00;

  // reset values of the configuration registers
  localparam logic [2:0] RST_BRIGHTNESS     = 3'd1;
  localparam logic       RST_DISPLAY_ENABLE = 1'b1;
  localparam logic [7:0] RST_ACK_WAIT_LIMIT = 8'd250;
  localparam logic [7:0] RST_TICKS_PER_US   = 8'd1;

  // step hold times in microseconds
  localparam logic [2:0] US_ZERO  = 3'd0;
  localparam logic [2:0] US_START = 3'd2;
  localparam logic [2:0] US_BIT   = 3'd3;
  localparam logic [2:0] US_ACK   = 3'd5;
  localparam logic [2:0] US_CLK   = 3'd2;
  localparam logic [2:0] US_STOP  = 3'd2;

  // segment pattern of a glyph index
  function automatic logic [7:0] seg_lookup(input logic [4:0] g);
    logic [7:0] s;
    case (g)
      5'd0:    s = 8'h3F;
      5'd1:    s = 8'h06;
      5'd2:    s = 8'h5B;
      5'd3:    s = 8'h4F;
      5'd4:    s = 8'h66;
      5'd5:    s = 8'h6D;
      5'd6:    s = 8'h7D;
      5'd7:    s = 8'h07;
      5'd8:    s = 8'h7F;
      5'd9:    s = 8'h6F;
      5'd10:   s = 8'h77;
      5'd11:   s = 8'h7C;
      5'd12:   s = 8'h58;
      5'd13:   s = 8'h5E;
      5'd14:   s = 8'h79;
      5'd15:   s = 8'h71;
      5'd16:   s = 8'h76;
      5'd17:   s = 8'h38;
      5'd18:   s = 8'h54;
      5'd19:   s = 8'h73;
      5'd20:   s = 8'h3E;
      default: s = SEG_BLANK;
    endcase
    return s;
  endfunction

endpackage

`default_nettype wire

@@ hw/rtl/svsw_glyph_enc.sv @@
`timescale 1ns / 1ps
`default_nettype none

module svsw_glyph_enc #(
  parameter int DIGIT_COUNT = 4,
  parameter int GLYPH_COUNT = 22
) (
  input  svsw_pkg::in_t                    req,
  output logic [DIGIT_COUNT-1:0][7:0]      seg_bytes
);

  logic [3:0][4:0] glyph;

  assign glyph = {req.glyph_3, req.glyph_2, req.glyph_1, req.glyph_0};

  // table lookup per digit, blank past the glyph count or the fourth digit
  for (genvar i = 0; i < DIGIT_COUNT; i++) begin : g_digit
    logic [7:0] base;
    if (i < 4) begin : g_have
      assign base = ({1'b0, glyph[i]} < 6'(GLYPH_COUNT)) ?
                    svsw_pkg::seg_lookup(glyph[i]) : svsw_pkg::SEG_BLANK;
    end else begin : g_none
      assign base = svsw_pkg::SEG_BLANK;
    end
    // colon rides on bit 7 of the second digit
    if (i == 1) begin : g_colon
      assign seg_bytes[i] = req.colon_on ? (base | svsw_pkg::COLON_MASK) : base;
    end else begin : g_plain
      assign seg_bytes[i] = base;
    end
  end

endmodule

`default_nettype wire

@@ hw/rtl/svsw_seq.sv @@
`timescale 1ns / 1ps
`default_nettype none

module svsw_seq #(
  parameter int DIGIT_COUNT = 4
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          tick,
  input  svsw_pkg::in_t                 req,
  input  logic [DIGIT_COUNT-1:0][7:0]   seg_in,
  input  svsw_pkg::cfg_t                cfg,
  output svsw_pkg::out_t                res
);

  localparam int IDX_W = $clog2(DIGIT_COUNT + 3);
  localparam int SEG_W = (DIGIT_COUNT > 1) ? $clog2(DIGIT_COUNT) : 1;

  svsw_pkg::step_t  step_r, step_nxt;
  logic [2:0]       bit_cnt_r, bit_cnt_nxt;
  logic [10:0]      delay_r, delay_nxt;
  logic [7:0]       ack_cnt_r, ack_cnt_nxt;
  logic [7:0]       shift_r, shift_nxt;
  logic             fail_r, fail_nxt;
  logic             clk_lvl_r, clk_lvl_nxt;
  logic             dat_lvl_r, dat_lvl_nxt;
  logic [IDX_W-1:0] byte_idx_r, byte_idx_nxt;
  logic [7:0]       seg_r [DIGIT_COUNT];

  logic             enter_en;
  logic             load_seg;
  logic             done;
  logic [2:0]       hold_us;
  logic [10:0]      hold_prod;
  logic [10:0]      hold_ticks;
  logic [IDX_W-1:0] sel_idx;
  logic [IDX_W-1:0] seg_off;
  logic [7:0]       sel_byte;

  // byte to load: next index when coming from an acknowledge
  assign sel_idx = (step_r == svsw_pkg::ST_AK4) ? (byte_idx_r + IDX_W'(1)) : byte_idx_r;
  assign seg_off = sel_idx - IDX_W'(2);

  always_comb begin
    if (sel_idx == IDX_W'(0)) begin
      sel_byte = svsw_pkg::CMD_AUTO_INC;
    end else if (sel_idx == IDX_W'(1)) begin
      sel_byte = svsw_pkg::CMD_ADDR;
    end else if (sel_idx < IDX_W'(2 + DIGIT_COUNT)) begin
      sel_byte = seg_r[seg_off[SEG_W-1:0]];
    end else begin
      sel_byte = svsw_pkg::CMD_DISP | {4'b0000, cfg.display_enable, cfg.brightness};
    end
  end

  // next step and counters
  always_comb begin
    step_nxt     = step_r;
    bit_cnt_nxt  = bit_cnt_r;
    delay_nxt    = delay_r;
    ack_cnt_nxt  = ack_cnt_r;
    shift_nxt    = shift_r;
    fail_nxt     = fail_r;
    byte_idx_nxt = byte_idx_r;
    enter_en     = 1'b0;
    load_seg     = 1'b0;
    done         = 1'b0;
    if (tick) begin
      if (step_r == svsw_pkg::ST_IDLE) begin
        if (req.req_valid) begin
          load_seg     = 1'b1;
          fail_nxt     = 1'b0;
          byte_idx_nxt = '0;
          step_nxt     = svsw_pkg::ST_ST1;
          enter_en     = 1'b1;
        end
      end else if (step_r == svsw_pkg::ST_AK2) begin
        // acknowledge poll
        if (!req.data_line_in) begin
          step_nxt = svsw_pkg::ST_AK3;
          enter_en = 1'b1;
        end else if (ack_cnt_r >= cfg.ack_wait_limit) begin
          fail_nxt = 1'b1;
          step_nxt = svsw_pkg::ST_AK3;
          enter_en = 1'b1;
        end else begin
          ack_cnt_nxt = ack_cnt_r + 8'd1;
        end
      end else if (delay_r != 11'd0) begin
        delay_nxt = delay_r - 11'd1;
      end else begin
        enter_en = 1'b1;
        unique case (step_r)
          svsw_pkg::ST_ST1: step_nxt = svsw_pkg::ST_ST2;
          svsw_pkg::ST_ST2: begin
            shift_nxt   = sel_byte;
            bit_cnt_nxt = 3'd0;
            step_nxt    = svsw_pkg::ST_BLO;
          end
          svsw_pkg::ST_BLO: step_nxt = svsw_pkg::ST_BHI;
          svsw_pkg::ST_BHI: begin
            shift_nxt = {1'b0, shift_r[7:1]};
            if (bit_cnt_r == 3'd7) begin
              step_nxt = svsw_pkg::ST_AK1;
            end else begin
              bit_cnt_nxt = bit_cnt_r + 3'd1;
              step_nxt    = svsw_pkg::ST_BLO;
            end
          end
          svsw_pkg::ST_AK1: begin
            ack_cnt_nxt = 8'd0;
            step_nxt    = svsw_pkg::ST_AK2;
          end
          svsw_pkg::ST_AK3: step_nxt = svsw_pkg::ST_AK4;
          svsw_pkg::ST_AK4: begin
            // auto-increment, last digit and display bytes each end a transaction
            if (byte_idx_r == IDX_W'(0) || byte_idx_r >= IDX_W'(1 + DIGIT_COUNT)) begin
              step_nxt = svsw_pkg::ST_SP1;
            end else begin
              byte_idx_nxt = sel_idx;
              shift_nxt    = sel_byte;
              bit_cnt_nxt  = 3'd0;
              step_nxt     = svsw_pkg::ST_BLO;
            end
          end
          svsw_pkg::ST_SP1: step_nxt = svsw_pkg::ST_SP2;
          svsw_pkg::ST_SP2: step_nxt = svsw_pkg::ST_SP3;
          svsw_pkg::ST_SP3: step_nxt = svsw_pkg::ST_SP4;
          svsw_pkg::ST_SP4: begin
            if (byte_idx_r >= IDX_W'(2 + DIGIT_COUNT)) begin
              step_nxt = svsw_pkg::ST_IDLE;
              enter_en = 1'b0;
              done     = 1'b1;
            end else begin
              byte_idx_nxt = byte_idx_r + IDX_W'(1);
              step_nxt     = svsw_pkg::ST_ST1;
            end
          end
          default: begin
            step_nxt = svsw_pkg::ST_IDLE;
            enter_en = 1'b0;
          end
        endcase
      end
    end
  end

  // pin levels and hold time on entering a step
  always_comb begin
    clk_lvl_nxt = clk_lvl_r;
    dat_lvl_nxt = dat_lvl_r;
    hold_us     = svsw_pkg::US_ZERO;
    if (enter_en) begin
      unique case (step_nxt)
        svsw_pkg::ST_ST1: begin
          clk_lvl_nxt = 1'b1;
          dat_lvl_nxt = 1'b1;
          hold_us     = svsw_pkg::US_START;
        end
        svsw_pkg::ST_ST2: dat_lvl_nxt = 1'b0;
        svsw_pkg::ST_BLO: begin
          clk_lvl_nxt = 1'b0;
          dat_lvl_nxt = shift_nxt[0];
          hold_us     = svsw_pkg::US_BIT;
        end
        svsw_pkg::ST_BHI: begin
          clk_lvl_nxt = 1'b1;
          hold_us     = svsw_pkg::US_BIT;
        end
        svsw_pkg::ST_AK1: begin
          clk_lvl_nxt = 1'b0;
          dat_lvl_nxt = 1'b1;
          hold_us     = svsw_pkg::US_ACK;
        end
        svsw_pkg::ST_AK3: begin
          clk_lvl_nxt = 1'b1;
          hold_us     = svsw_pkg::US_CLK;
        end
        svsw_pkg::ST_AK4: clk_lvl_nxt = 1'b0;
        svsw_pkg::ST_SP1: begin
          clk_lvl_nxt = 1'b0;
          hold_us     = svsw_pkg::US_STOP;
        end
        svsw_pkg::ST_SP2: begin
          dat_lvl_nxt = 1'b0;
          hold_us     = svsw_pkg::US_STOP;
        end
        svsw_pkg::ST_SP3: begin
          clk_lvl_nxt = 1'b1;
          hold_us     = svsw_pkg::US_STOP;
        end
        svsw_pkg::ST_SP4: begin
          dat_lvl_nxt = 1'b1;
          hold_us     = svsw_pkg::US_STOP;
        end
        default: hold_us = svsw_pkg::US_ZERO;
      endcase
    end
  end

  // hold ticks minus one, floor zero
  assign hold_prod  = 11'(hold_us) * 11'(cfg.ticks_per_us);
  assign hold_ticks = (hold_prod != 11'd0) ? (hold_prod - 11'd1) : 11'd0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_r     <= svsw_pkg::ST_IDLE;
      bit_cnt_r  <= '0;
      delay_r    <= '0;
      ack_cnt_r  <= '0;
      shift_r    <= '0;
      fail_r     <= 1'b0;
      clk_lvl_r  <= 1'b1;
      dat_lvl_r  <= 1'b1;
      byte_idx_r <= '0;
    end else begin
      step_r     <= step_nxt;
      bit_cnt_r  <= bit_cnt_nxt;
      delay_r    <= enter_en ? hold_ticks : delay_nxt;
      ack_cnt_r  <= ack_cnt_nxt;
      shift_r    <= shift_nxt;
      fail_r     <= fail_nxt;
      clk_lvl_r  <= clk_lvl_nxt;
      dat_lvl_r  <= dat_lvl_nxt;
      byte_idx_r <= byte_idx_nxt;
    end
  end

  // segment bytes captured at request
  always_ff @(posedge clk) begin
    if (load_seg) begin
      for (int i = 0; i < DIGIT_COUNT; i++) begin
        seg_r[i] <= seg_in[i];
      end
    end
  end

  // result of this tick
  always_comb begin
    res.clock_line    = clk_lvl_nxt;
    res.data_line_out = dat_lvl_nxt;
    res.busy_res      = (step_nxt != svsw_pkg::ST_IDLE);
    res.done_res      = done;
    res.ack_missing   = done & fail_nxt;
  end

endmodule

`default_nettype wire

@@ hw/rtl/seven_segment_two_wire_writer_core.sv @@
`timescale 1ns / 1ps
`default_nettype none

// Pin sequencer for a two-wire seven-segment LED driver.
// Input channel (in_valid / in_stall / in_data): one request per time tick,
// carrying the sampled data line and, optionally, a display update with four
// glyph indices and a colon bit. An update is taken only while idle.
// Result channel (out_valid / out_stall / out_data): exactly one result per
// request with the clock and data pin levels, busy, and a one-tick done with
// the acknowledge-miss flag.
// Configuration (cfg_valid / cfg_ready / cfg_index / cfg_data): brightness,
// display enable, acknowledge timeout and ticks per microsecond. Always ready;
// write only while no update is running.
// Timing: a result shows on out_data in the cycle after its request is
// accepted. Throughput: one request per cycle unless the receiver stalls, set
// by the single state update between the sequencer and result registers.
// Reset: pins released high, sequencer idle, registers at defaults, no result.
// When the receiver stalls, the result register holds and in_stall rises,
// so no request is accepted until the result is taken.

module seven_segment_two_wire_writer_core #(
  parameter int DIGIT_COUNT = 4,
  parameter int GLYPH_COUNT = 22
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  output logic            in_stall,
  input  svsw_pkg::in_t   in_data,
  output logic            out_valid,
  input  logic            out_stall,
  output svsw_pkg::out_t  out_data,
  input  logic            cfg_valid,
  output logic            cfg_ready,
  input  logic [1:0]      cfg_index,
  input  logic [7:0]      cfg_data
);

  svsw_pkg::cfg_t                 cfg_r;
  svsw_pkg::out_t                 res;
  svsw_pkg::out_t                 out_data_r;
  logic                           out_valid_r;
  logic                           in_acc;
  logic [DIGIT_COUNT-1:0][7:0]    seg_bytes;

  assign cfg_ready = 1'b1;
  assign in_stall  = out_valid_r & out_stall;
  assign in_acc    = in_valid & ~in_stall;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.brightness     <= svsw_pkg::RST_BRIGHTNESS;
      cfg_r.display_enable <= svsw_pkg::RST_DISPLAY_ENABLE;
      cfg_r.ack_wait_limit <= svsw_pkg::RST_ACK_WAIT_LIMIT;
      cfg_r.ticks_per_us   <= svsw_pkg::RST_TICKS_PER_US;
    end else if (cfg_valid && cfg_ready) begin
      unique case (svsw_pkg::cfg_reg_t'(cfg_index))
        svsw_pkg::REG_BRIGHTNESS:     cfg_r.brightness     <= cfg_data[2:0];
        svsw_pkg::REG_DISPLAY_ENABLE: cfg_r.display_enable <= cfg_data[0];
        svsw_pkg::REG_ACK_WAIT_LIMIT: cfg_r.ack_wait_limit <= cfg_data;
        svsw_pkg::REG_TICKS_PER_US:   cfg_r.ticks_per_us   <= cfg_data;
        default:                      cfg_r <= cfg_r;
      endcase
    end
  end

  svsw_glyph_enc #(
    .DIGIT_COUNT (DIGIT_COUNT),
    .GLYPH_COUNT (GLYPH_COUNT)
  ) u_glyph_enc (
    .req       (in_data),
    .seg_bytes (seg_bytes)
  );

  svsw_seq #(
    .DIGIT_COUNT (DIGIT_COUNT)
  ) u_seq (
    .clk    (clk),
    .rst_n  (rst_n),
    .tick   (in_acc),
    .req    (in_data),
    .seg_in (seg_bytes),
    .cfg    (cfg_r),
    .res    (res)
  );

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (in_acc) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      out_data_r <= res;
    end
  end

  // a miss flag only comes with the finishing tick
  a_miss_with_done: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_data_r.ack_missing |-> out_data_r.done_res)
    else $error("ack_missing without done");

  // finishing tick is never reported busy
  a_done_not_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_data_r.done_res |-> !out_data_r.busy_res)
    else $error("done while busy");

  // between updates both lines rest released high
  a_idle_released: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !out_data_r.busy_res |->
      out_data_r.clock_line && out_data_r.data_line_out)
    else $error("lines not released while idle");

endmodule

`default_nettype wire

@@ dv/tb_top.sv @@
`timescale 1ns / 1ps

module tb_top;

  localparam int DIGITS      = 4;
  localparam int GLYPHS      = 22;
  localparam int CYCLE_LIMIT = 2_000_000;
  localparam int DRAIN_BATCH = 16;

  // frame bytes of the three transactions
  localparam logic [7:0] FRAME_AUTO_INC = 8'h40;
  localparam logic [7:0] FRAME_ADDR     = 8'hC0;
  localparam logic [3:0] FRAME_CTRL_HI  = 4'h8;

  // segment patterns, glyph 0 in the low byte
  localparam logic [GLYPHS*8-1:0] SEG_ROM = {
    8'h00, 8'h3E, 8'h73, 8'h54, 8'h38, 8'h76, 8'h71, 8'h79, 8'h5E, 8'h58, 8'h7C,
    8'h77, 8'h6F, 8'h7F, 8'h07, 8'h7D, 8'h6D, 8'h66, 8'h4F, 8'h5B, 8'h06, 8'h3F
  };

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               in_valid = 1'b0;
  logic               in_stall;
  svsw_pkg::in_t      in_data = '0;
  logic               out_valid;
  logic               out_stall = 1'b0;
  svsw_pkg::out_t     out_data;
  logic               cfg_valid = 1'b0;
  logic               cfg_ready;
  svsw_pkg::cfg_reg_t cfg_index = svsw_pkg::REG_BRIGHTNESS;
  logic [7:0]         cfg_data = '0;

  seven_segment_two_wire_writer_core dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always #2 clk = ~clk;

  // pending ticks and predicted pin levels
  svsw_pkg::in_t  tick_q[$];
  svsw_pkg::out_t pin_q[$];

  int unsigned send_gap_pct   = 0;
  int unsigned recv_stall_pct = 0;
  int unsigned line_low_pct   = 100;
  logic        in_fire = 1'b0;

  int unsigned n_pushed   = 0;
  int unsigned n_checked  = 0;
  int unsigned n_updates  = 0;
  int unsigned n_missed   = 0;
  int unsigned cfg_writes = 0;
  int unsigned n_errors   = 0;
  int unsigned cycles     = 0;

  // sequencer mirror: registers
  logic [2:0] bright_r = 3'd1;
  logic       enable_r = 1'b1;
  logic [7:0] limit_r  = 8'd250;
  logic [7:0] tpu_r    = 8'd1;

  // sequencer mirror: state
  svsw_pkg::step_t seq_step  = svsw_pkg::ST_IDLE;
  logic [2:0]      bit_idx   = '0;
  logic [10:0]     hold_left = '0;
  logic [7:0]      poll_cnt  = '0;
  logic [7:0]      seg_bytes [DIGITS];
  logic [7:0]      shift_reg = '0;
  logic            ack_lost  = 1'b0;
  logic            scl_lv    = 1'b1;
  logic            sda_lv    = 1'b1;
  int unsigned     byte_sel  = 0;

  function automatic logic [7:0] seg_of(logic [4:0] g);
    return (int'(g) < GLYPHS) ? SEG_ROM[int'(g)*8 +: 8] : 8'h00;
  endfunction

  // a step lasts us * ticks_per_us ticks, at least one
  function automatic void set_hold(int unsigned us);
    int unsigned t;
    t = us * tpu_r;
    hold_left = (t != 0) ? 11'(t - 1) : 11'd0;
  endfunction

  function automatic void go_step(svsw_pkg::step_t s);
    seq_step = s;
    case (s)
      svsw_pkg::ST_ST1: begin scl_lv = 1'b1; sda_lv = 1'b1; set_hold(2); end
      svsw_pkg::ST_ST2: begin sda_lv = 1'b0; set_hold(0); end
      svsw_pkg::ST_BLO: begin scl_lv = 1'b0; sda_lv = shift_reg[0]; set_hold(3); end
      svsw_pkg::ST_BHI: begin scl_lv = 1'b1; set_hold(3); end
      svsw_pkg::ST_AK1: begin scl_lv = 1'b0; sda_lv = 1'b1; set_hold(5); end
      svsw_pkg::ST_AK2: begin poll_cnt = '0; set_hold(0); end
      svsw_pkg::ST_AK3: begin scl_lv = 1'b1; set_hold(2); end
      svsw_pkg::ST_AK4: begin scl_lv = 1'b0; set_hold(0); end
      svsw_pkg::ST_SP1: begin scl_lv = 1'b0; set_hold(2); end
      svsw_pkg::ST_SP2: begin sda_lv = 1'b0; set_hold(2); end
      svsw_pkg::ST_SP3: begin scl_lv = 1'b1; set_hold(2); end
      svsw_pkg::ST_SP4: begin sda_lv = 1'b1; set_hold(2); end
      default: hold_left = '0;
    endcase
  endfunction

  // pick the byte at the current frame position and start shifting it
  function automatic void load_next();
    if (byte_sel == 0) shift_reg = FRAME_AUTO_INC;
    else if (byte_sel == 1) shift_reg = FRAME_ADDR;
    else if (byte_sel < 2 + DIGITS) shift_reg = seg_bytes[byte_sel - 2];
    else shift_reg = {FRAME_CTRL_HI, enable_r, bright_r};
    bit_idx = '0;
    go_step(svsw_pkg::ST_BLO);
  endfunction

  // one tick of the pin sequencer
  function automatic svsw_pkg::out_t predict_tick(svsw_pkg::in_t t);
    svsw_pkg::out_t r;
    logic fin;
    fin = 1'b0;
    if (seq_step == svsw_pkg::ST_IDLE) begin
      if (t.req_valid) begin
        seg_bytes[0] = seg_of(t.glyph_0);
        seg_bytes[1] = seg_of(t.glyph_1) | {t.colon_on, 7'b0};
        seg_bytes[2] = seg_of(t.glyph_2);
        seg_bytes[3] = seg_of(t.glyph_3);
        ack_lost = 1'b0;
        byte_sel = 0;
        go_step(svsw_pkg::ST_ST1);
      end
    end else if (seq_step == svsw_pkg::ST_AK2) begin
      // acknowledge poll on the sampled data line
      if (!t.data_line_in) begin
        go_step(svsw_pkg::ST_AK3);
      end else if (poll_cnt >= limit_r) begin
        ack_lost = 1'b1;
        go_step(svsw_pkg::ST_AK3);
      end else begin
        poll_cnt++;
      end
    end else if (hold_left != 0) begin
      hold_left--;
    end else begin
      case (seq_step)
        svsw_pkg::ST_ST1: go_step(svsw_pkg::ST_ST2);
        svsw_pkg::ST_ST2: load_next();
        svsw_pkg::ST_BLO: go_step(svsw_pkg::ST_BHI);
        svsw_pkg::ST_BHI: begin
          shift_reg = shift_reg >> 1;
          if (bit_idx == 3'd7) begin
            go_step(svsw_pkg::ST_AK1);
          end else begin
            bit_idx++;
            go_step(svsw_pkg::ST_BLO);
          end
        end
        svsw_pkg::ST_AK1: go_step(svsw_pkg::ST_AK2);
        svsw_pkg::ST_AK3: go_step(svsw_pkg::ST_AK4);
        svsw_pkg::ST_AK4: begin
          if (byte_sel == 0 || byte_sel >= 1 + DIGITS) begin
            go_step(svsw_pkg::ST_SP1);
          end else begin
            byte_sel++;
            load_next();
          end
        end
        svsw_pkg::ST_SP1: go_step(svsw_pkg::ST_SP2);
        svsw_pkg::ST_SP2: go_step(svsw_pkg::ST_SP3);
        svsw_pkg::ST_SP3: go_step(svsw_pkg::ST_SP4);
        svsw_pkg::ST_SP4: begin
          if (byte_sel >= 2 + DIGITS) begin
            seq_step = svsw_pkg::ST_IDLE;
            fin = 1'b1;
          end else begin
            byte_sel++;
            go_step(svsw_pkg::ST_ST1);
          end
        end
        default: seq_step = svsw_pkg::ST_IDLE;
      endcase
    end
    r.clock_line    = scl_lv;
    r.data_line_out = sda_lv;
    r.busy_res      = (seq_step != svsw_pkg::ST_IDLE);
    r.done_res      = fin;
    r.ack_missing   = fin & ack_lost;
    return r;
  endfunction

  function automatic void check_bit(string name, logic want, logic got);
    if (want !== got) begin
      $error("mismatch on %s: expected %0d, got %0d", name, want, got);
      n_errors++;
    end
  endfunction

  // cycle limit
  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  // request driver and receiver stalls, both change at the falling edge
  always @(negedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (!in_valid || in_fire) begin
      if (tick_q.size() != 0 && $urandom_range(99) >= send_gap_pct) begin
        in_valid <= 1'b1;
        in_data  <= tick_q.pop_front();
      end else begin
        in_valid <= 1'b0;
      end
    end
    out_stall <= ($urandom_range(99) < recv_stall_pct);
  end

  // monitor: register writes, accepted requests and results
  always @(posedge clk) begin : mon
    svsw_pkg::out_t want;
    if (rst_n) begin
      in_fire <= in_valid && !in_stall;
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          svsw_pkg::REG_BRIGHTNESS:     bright_r = cfg_data[2:0];
          svsw_pkg::REG_DISPLAY_ENABLE: enable_r = cfg_data[0];
          svsw_pkg::REG_ACK_WAIT_LIMIT: limit_r  = cfg_data;
          svsw_pkg::REG_TICKS_PER_US:   tpu_r    = cfg_data;
          default: ;
        endcase
        cfg_writes++;
      end
      // results first, so a request taken at this edge is not matched here
      if (out_valid && !out_stall) begin
        if (pin_q.size() == 0) begin
          $error("result with no pending request: %p", out_data);
          n_errors++;
        end else begin
          want = pin_q.pop_front();
          check_bit("clock_line", want.clock_line, out_data.clock_line);
          check_bit("data_line_out", want.data_line_out, out_data.data_line_out);
          check_bit("busy_res", want.busy_res, out_data.busy_res);
          check_bit("done_res", want.done_res, out_data.done_res);
          check_bit("ack_missing", want.ack_missing, out_data.ack_missing);
        end
        n_checked++;
      end
      if (in_valid && !in_stall) begin
        want = predict_tick(in_data);
        if (want.done_res) n_updates++;
        if (want.ack_missing) n_missed++;
        pin_q.push_back(want);
      end
    end
  end

  function automatic svsw_pkg::in_t build_tick(logic req, logic [4:0] g0, logic [4:0] g1,
                                               logic [4:0] g2, logic [4:0] g3,
                                               logic colon, logic line);
    svsw_pkg::in_t t;
    t.req_valid    = req;
    t.glyph_0      = g0;
    t.glyph_1      = g1;
    t.glyph_2      = g2;
    t.glyph_3      = g3;
    t.colon_on     = colon;
    t.data_line_in = line;
    return t;
  endfunction

  // mostly valid glyphs, some blanks above the table
  function automatic logic [4:0] pick_glyph();
    return ($urandom_range(9) < 8) ? 5'($urandom_range(GLYPHS - 1))
                                   : 5'($urandom_range(31, GLYPHS));
  endfunction

  function automatic svsw_pkg::in_t rand_tick(int unsigned req_pct);
    return build_tick($urandom_range(99) < req_pct, pick_glyph(), pick_glyph(),
                      pick_glyph(), pick_glyph(), 1'($urandom_range(1)),
                      $urandom_range(99) >= line_low_pct);
  endfunction

  task automatic push_tick(svsw_pkg::in_t t);
    tick_q.push_back(t);
    n_pushed++;
  endtask

  task automatic push_update(logic [4:0] g0, logic [4:0] g1, logic [4:0] g2,
                             logic [4:0] g3, logic colon);
    push_tick(build_tick(1'b1, g0, g1, g2, g3, colon, line_low_pct == 0));
  endtask

  // feed idle ticks until the sequencer is back at rest and every result is in
  task automatic settle();
    bit at_rest;
    at_rest = 1'b0;
    while (!at_rest) begin
      @(negedge clk);
      if (n_checked == n_pushed && tick_q.size() == 0) begin
        if (seq_step == svsw_pkg::ST_IDLE) begin
          at_rest = 1'b1;
        end else begin
          repeat (DRAIN_BATCH) push_tick(rand_tick(0));
        end
      end
    end
  endtask

  task automatic cfg_write(svsw_pkg::cfg_reg_t idx, logic [7:0] val);
    int unsigned seen;
    @(negedge clk);
    seen = cfg_writes;
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    while (cfg_writes == seen) @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic cfg_all(logic [2:0] br, logic en, logic [7:0] lim, logic [7:0] tpu);
    cfg_write(svsw_pkg::REG_BRIGHTNESS, {5'b0, br});
    cfg_write(svsw_pkg::REG_DISPLAY_ENABLE, {7'b0, en});
    cfg_write(svsw_pkg::REG_ACK_WAIT_LIMIT, lim);
    cfg_write(svsw_pkg::REG_TICKS_PER_US, tpu);
  endtask

  initial begin : stim
    int unsigned lim;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // reset settings, acknowledge answered at once
    line_low_pct = 100;
    push_tick(build_tick(1'b0, 5'd0, 5'd0, 5'd0, 5'd0, 1'b0, 1'b0));
    push_tick(build_tick(1'b0, 5'd31, 5'd31, 5'd31, 5'd31, 1'b1, 1'b1));
    push_update(5'd0, 5'd1, 5'd2, 5'd3, 1'b0);
    // update request while busy is dropped
    push_update(5'd31, 5'd31, 5'd31, 5'd31, 1'b1);
    settle();

    // one-tick steps, full brightness, display off, zero timeout with the
    // data line stuck high, last table entries and blank glyphs
    line_low_pct = 0;
    cfg_all(3'd7, 1'b0, 8'd0, 8'd0);
    push_update(5'd20, 5'd21, 5'd22, 5'd31, 1'b1);
    settle();

    // random phases: ignored requests while a sequence runs
    for (int p = 0; p < 4; p++) begin
      case (p)
        0: begin send_gap_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_gap_pct = 82; recv_stall_pct = 0;  end
        2: begin send_gap_pct = 0;  recv_stall_pct = 82; end
        default: begin send_gap_pct = 33; recv_stall_pct = 33; end
      endcase
      case ($urandom_range(3))
        0: lim = 0;
        1: lim = $urandom_range(1, 4);
        2: lim = $urandom_range(5, 40);
        default: lim = $urandom_range(1, 255);
      endcase
      case ($urandom_range(2))
        0: line_low_pct = 20;
        1: line_low_pct = 50;
        default: line_low_pct = 90;
      endcase
      cfg_all(3'($urandom_range(7)), 1'(p % 2), 8'(lim), 8'd0);
      repeat (100) push_tick(rand_tick(25));
      settle();
    end

    repeat (4) @(posedge clk);
    $display("ran %0d ticks through %0d register writes", n_pushed, cfg_writes);
    $display("%0d display updates finished, %0d with a missed acknowledge",
             n_updates, n_missed);
    if (n_errors == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
